@@ rtl/led_ripple_animation_scheduler_top_macros.svh @@
// Assertion macros shared by the LED ripple animation scheduler modules.
`ifndef LED_RIPPLE_ANIMATION_SCHEDULER_TOP_MACROS_SVH
`define LED_RIPPLE_ANIMATION_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clock and disabled while reset is high.
`define LRAS_ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled while reset is high.
`define LRAS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/lras_pkg.sv @@
// Types and fixed constants of the LED ripple animation scheduler.
package lras_pkg;

   localparam int LIGHT_W      = 6;
   localparam int LIGHT_SPAN   = 2 ** LIGHT_W;
   localparam int HUE_W        = 16;
   localparam int VALUE_W      = 6;
   localparam int RIPPLE_LEN   = 25;
   localparam int RIPPLE_REACH = 10;
   localparam int VALUE_STEP   = 2;
   localparam int PEAK_VALUE   = RIPPLE_LEN * VALUE_STEP;
   localparam int STEP_W       = 5;
   localparam int REACH_W      = 4;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_HIT  = 1'b1;

   // One light of one frame; a blank light is stored as all zero.
   typedef struct packed {
      logic [HUE_W-1:0]   hue;
      logic [VALUE_W-1:0] value;
   } entry_type;

   // Control from the sequencer to the render stage.
   typedef struct packed {
      logic               lookup;
      logic [LIGHT_W-1:0] light;
      logic               finish;
   } render_ctl_type;

endpackage

@@ rtl/lras_render.sv @@
// Render stage: compares frame entries with the shown state and emits pixel writes.
`include "led_ripple_animation_scheduler_top_macros.svh"

module lras_render (
   input  logic                          clock,
   input  logic                          reset,
   input  lras_pkg::render_ctl_type      ctl,
   input  lras_pkg::entry_type           rd_entry,
   output logic                          rsp_strobe,
   output logic                          rsp_pixel_valid,
   output logic [lras_pkg::LIGHT_W-1:0]  rsp_pixel_index,
   output logic [lras_pkg::HUE_W-1:0]    rsp_pixel_hue,
   output logic [lras_pkg::VALUE_W-1:0]  rsp_pixel_value,
   output logic                          rsp_show
);
   import lras_pkg::*;

   logic [LIGHT_SPAN-1:0] shown_lit_ff;
   logic                  pend_vld_ff;
   logic [LIGHT_W-1:0]    pend_light_ff;
   entry_type             pend_entry_ff;

   logic                  strobe_ff, strobe_in;
   logic                  valid_ff, valid_in;
   logic [LIGHT_W-1:0]    index_ff, index_in;
   entry_type             pix_ff, pix_in;
   logic                  show_ff, show_in;

   logic                  lit;

   assign lit = (rd_entry.value != '0) || shown_lit_ff[ctl.light];

   // The newest write is held back one step so the last one can carry show.
   always_comb begin
      strobe_in = 1'b0;
      valid_in  = 1'b0;
      index_in  = '0;
      pix_in    = '0;
      show_in   = 1'b0;
      if (ctl.lookup && lit && pend_vld_ff) begin
         strobe_in = 1'b1;
         valid_in  = 1'b1;
         index_in  = pend_light_ff;
         pix_in    = pend_entry_ff;
      end else if (ctl.finish) begin
         strobe_in = 1'b1;
         show_in   = 1'b1;
         if (pend_vld_ff) begin
            valid_in = 1'b1;
            index_in = pend_light_ff;
            pix_in   = pend_entry_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shown_lit_ff <= '0;
         pend_vld_ff  <= 1'b0;
         strobe_ff    <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
         if (ctl.lookup && lit) begin
            shown_lit_ff[ctl.light] <= (rd_entry.value != '0);
            pend_vld_ff             <= 1'b1;
         end else if (ctl.finish) begin
            pend_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      valid_ff <= valid_in;
      index_ff <= index_in;
      pix_ff   <= pix_in;
      show_ff  <= show_in;
      if (ctl.lookup && lit) begin
         pend_light_ff <= ctl.light;
         pend_entry_ff <= rd_entry;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_pixel_valid = valid_ff;
   assign rsp_pixel_index = index_ff;
   assign rsp_pixel_hue   = pix_ff.hue;
   assign rsp_pixel_value = pix_ff.value;
   assign rsp_show        = show_ff;

   `LRAS_ASSERT_HOLDS(a_show_has_strobe, rsp_show, rsp_strobe, "show without strobe")
   `LRAS_ASSERT_HOLDS(a_bare_is_show, rsp_strobe && !rsp_pixel_valid, rsp_show,
                      "bare marker that is not a show")
   `LRAS_ASSERT_HOLDS(a_blank_hue, rsp_strobe && (rsp_pixel_value == '0), rsp_pixel_hue == '0,
                      "blank pixel carries a hue")

endmodule

@@ rtl/led_ripple_animation_scheduler_top.sv @@
// Top level of the LED ripple animation scheduler: frame memory and sequencer.
//
//   channel   ports                               handshake
//   request   req_operation, req_light_index,     start high while busy low
//             req_hue
//   response  rsp_pixel_valid, rsp_pixel_index,   rsp_strobe, one cycle per transaction
//             rsp_pixel_hue, rsp_pixel_value,
//             rsp_show
//
// After reset the block clears the frame memory, one entry a cycle, all FRAMES * 64
// entries; busy stays high through the whole pass.
// A hit transaction makes one memory write per ripple entry, 415 writes in all.
// A tick transaction makes one memory read per light, then passes through a flush
// state that drains the read pipeline and a show state that emits the final show transaction.
// A hit whose light index lies beyond the strip is taken and dropped at once.
// Results cannot be held off by the receiver, so nothing in the block ever stalls.
`include "led_ripple_animation_scheduler_top_macros.svh"

module led_ripple_animation_scheduler_top #(
   parameter int NUM_LIGHTS = 64,
   parameter int FRAMES     = 128
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_operation,
   input  logic [lras_pkg::LIGHT_W-1:0]  req_light_index,
   input  logic [lras_pkg::HUE_W-1:0]    req_hue,
   output logic                          rsp_strobe,
   output logic                          rsp_pixel_valid,
   output logic [lras_pkg::LIGHT_W-1:0]  rsp_pixel_index,
   output logic [lras_pkg::HUE_W-1:0]    rsp_pixel_hue,
   output logic [lras_pkg::VALUE_W-1:0]  rsp_pixel_value,
   output logic                          rsp_show
);
   import lras_pkg::*;

   localparam int FRAME_W = $clog2(FRAMES);
   localparam int ADDR_W  = FRAME_W + LIGHT_W;
   localparam int DEPTH   = FRAMES * LIGHT_SPAN;

   localparam logic [LIGHT_W-1:0] LAST_LIGHT = LIGHT_W'(NUM_LIGHTS - 1);
   localparam logic [FRAME_W-1:0] RING_END   = FRAME_W'(FRAMES - 1);
   localparam logic [ADDR_W-1:0]  LAST_ADDR  = ADDR_W'(DEPTH - 1);

   // Sequencer states, one-hot.
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CLEAR = 6'b000010,
      ST_HIT   = 6'b000100,
      ST_TICK  = 6'b001000,
      ST_FLUSH = 6'b010000,
      ST_SHOW  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Frame memory, addressed by {frame, light}. Reads are read-before-write.
   entry_type frame_mem [DEPTH];
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   entry_type           mem_wdata;
   logic [ADDR_W-1:0]   mem_raddr;
   entry_type           rd_entry_ff;

   logic [FRAME_W-1:0]  frame_ptr_ff, frame_ptr_in;
   logic [ADDR_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [LIGHT_W-1:0]  light_ff, light_in;
   logic                rd_vld_ff;
   logic [LIGHT_W-1:0]  rd_light_ff;

   // Ripple walk: frame step, distance from the centre, side, and both edges.
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [REACH_W-1:0]  dist_ff, dist_in;
   logic                side_ff, side_in;
   logic [FRAME_W-1:0]  hit_frame_ff, hit_frame_in;
   logic [LIGHT_W-1:0]  centre_ff, centre_in;
   logic [LIGHT_W-1:0]  up_ff, up_in;
   logic [LIGHT_W-1:0]  dn_ff, dn_in;
   logic [VALUE_W-1:0]  peak_ff, peak_in;
   logic [HUE_W-1:0]    hue_ff, hue_in;

   logic [REACH_W-1:0]  reach;
   logic [VALUE_W-1:0]  drop;
   logic [VALUE_W-1:0]  side_value;
   logic [VALUE_W-1:0]  hit_value;
   logic [LIGHT_W-1:0]  hit_light;
   logic                frame_done;
   logic [LIGHT_W-1:0]  up_step;
   logic [LIGHT_W-1:0]  dn_step;
   logic [FRAME_W-1:0]  hit_frame_step;
   logic [FRAME_W-1:0]  frame_ptr_step;
   logic                accept;

   render_ctl_type      render_ctl;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // The ripple widens by one light per frame until it reaches ten on each side.
   assign reach      = (step_ff < STEP_W'(RIPPLE_REACH)) ? step_ff[REACH_W-1:0]
                                                         : REACH_W'(RIPPLE_REACH);
   assign drop       = VALUE_W'({dist_ff, 1'b0});
   assign side_value = (peak_ff > drop) ? (peak_ff - drop) : '0;
   assign hit_value  = (dist_ff == '0) ? peak_ff : side_value;
   assign hit_light  = (dist_ff == '0) ? centre_ff : (side_ff ? dn_ff : up_ff);
   assign frame_done = (dist_ff == reach) && ((dist_ff == '0) || side_ff);

   assign up_step        = (up_ff == LAST_LIGHT) ? '0 : up_ff + 1'b1;
   assign dn_step        = (dn_ff == '0) ? LAST_LIGHT : dn_ff - 1'b1;
   assign hit_frame_step = (hit_frame_ff == RING_END) ? '0 : hit_frame_ff + 1'b1;
   assign frame_ptr_step = (frame_ptr_ff == RING_END) ? '0 : frame_ptr_ff + 1'b1;

   // Memory port selection. Ticks read each light and clear it in the same cycle.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      mem_raddr = {frame_ptr_ff, light_ff};
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
         end
         ST_HIT: begin
            mem_we    = 1'b1;
            mem_waddr = {hit_frame_ff, hit_light};
            if (hit_value != '0) begin
               mem_wdata.hue   = hue_ff;
               mem_wdata.value = hit_value;
            end
         end
         ST_TICK: begin
            mem_we    = 1'b1;
            mem_waddr = {frame_ptr_ff, light_ff};
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_waddr] <= mem_wdata;
      end
      rd_entry_ff <= frame_mem[mem_raddr];
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      frame_ptr_in = frame_ptr_ff;
      clr_addr_in  = clr_addr_ff;
      light_in     = light_ff;
      step_in      = step_ff;
      dist_in      = dist_ff;
      side_in      = side_ff;
      hit_frame_in = hit_frame_ff;
      centre_in    = centre_ff;
      up_in        = up_ff;
      dn_in        = dn_ff;
      peak_in      = peak_ff;
      hue_in       = hue_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (req_operation == OP_HIT) begin
                  if ({1'b0, req_light_index} < (LIGHT_W + 1)'(NUM_LIGHTS)) begin
                     state_in     = ST_HIT;
                     step_in      = '0;
                     dist_in      = '0;
                     side_in      = 1'b0;
                     hit_frame_in = frame_ptr_ff;
                     centre_in    = req_light_index;
                     up_in        = req_light_index;
                     dn_in        = req_light_index;
                     peak_in      = VALUE_W'(PEAK_VALUE);
                     hue_in       = req_hue;
                  end
               end else begin
                  state_in = ST_TICK;
                  light_in = '0;
               end
            end
         end
         ST_HIT: begin
            if (frame_done) begin
               if (step_ff == STEP_W'(RIPPLE_LEN - 1)) begin
                  state_in = ST_IDLE;
               end
               step_in      = step_ff + 1'b1;
               dist_in      = '0;
               side_in      = 1'b0;
               hit_frame_in = hit_frame_step;
               up_in        = centre_ff;
               dn_in        = centre_ff;
               peak_in      = peak_ff - VALUE_W'(VALUE_STEP);
            end else if ((dist_ff == '0) || side_ff) begin
               dist_in = dist_ff + 1'b1;
               side_in = 1'b0;
               up_in   = up_step;
               dn_in   = dn_step;
            end else begin
               side_in = 1'b1;
            end
         end
         ST_TICK: begin
            light_in = light_ff + 1'b1;
            if (light_ff == LAST_LIGHT) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            state_in     = ST_IDLE;
            frame_ptr_in = frame_ptr_step;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         frame_ptr_ff <= '0;
         clr_addr_ff  <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         frame_ptr_ff <= frame_ptr_in;
         clr_addr_ff  <= clr_addr_in;
         rd_vld_ff    <= (state_ff == ST_TICK);
      end
   end

   always_ff @(posedge clock) begin
      light_ff     <= light_in;
      rd_light_ff  <= light_ff;
      step_ff      <= step_in;
      dist_ff      <= dist_in;
      side_ff      <= side_in;
      hit_frame_ff <= hit_frame_in;
      centre_ff    <= centre_in;
      up_ff        <= up_in;
      dn_ff        <= dn_in;
      peak_ff      <= peak_in;
      hue_ff       <= hue_in;
   end

   // The read data of light k arrives in the cycle after its address was issued.
   assign render_ctl.lookup = rd_vld_ff;
   assign render_ctl.light  = rd_light_ff;
   assign render_ctl.finish = (state_ff == ST_SHOW);

   lras_render u_render (
      .clock           (clock),
      .reset           (reset),
      .ctl             (render_ctl),
      .rd_entry        (rd_entry_ff),
      .rsp_strobe      (rsp_strobe),
      .rsp_pixel_valid (rsp_pixel_valid),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_pixel_hue   (rsp_pixel_hue),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_show        (rsp_show)
   );

   `LRAS_ASSERT_NEXT(a_tick_starts, accept && (req_operation == OP_TICK),
                     state_ff == ST_TICK, "accepted tick did not start a scan")
   `LRAS_ASSERT_NEXT(a_show_follows, state_ff == ST_SHOW, rsp_strobe && rsp_show,
                     "tick ended without a show transaction")
   `LRAS_ASSERT_HOLDS(a_quiet_outside_tick, rsp_strobe,
                      (state_ff != ST_HIT) && (state_ff != ST_CLEAR),
                      "response during a hit or the clearing pass")
   `LRAS_ASSERT_NEXT(a_pointer_moves_on_show, state_ff != ST_SHOW, $stable(frame_ptr_ff),
                     "frame pointer moved outside the end of a tick")

endmodule

@@ test/tb_led_ripple_animation_scheduler_top.sv @@
// Self-checking testbench for the LED ripple animation scheduler top level.
module tb_led_ripple_animation_scheduler_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lras_pkg::*;

   // The block is built with its default strip and ring sizes.
   localparam int NUM_LIGHTS = 64;
   localparam int FRAMES     = 128;

   // The longest quiet stretch of a correct run is the clearing pass after reset
   // plus the widest sender gap; a hit alone is much shorter.
   // The watchdog allows several times that.
   localparam int STALL_LIMIT   = 40000;
   // After the last expected result, give the block room for one more hit.
   localparam int SETTLE_CYCLES = 1000;
   localparam int MAX_GAP       = 11;
   localparam int RANDOM_ITEMS  = 350;
   localparam int HALF_PERIOD   = 6;

   // One pending transaction for the driver, with the idle cycles that precede it
   // and a flag that holds it back until every expected pixel write has come.
   typedef struct {
      logic               operation;
      logic [LIGHT_W-1:0] light;
      logic [HUE_W-1:0]   hue;
      int                 gap;
      bit                 drain;
   } command_type;

   // One pixel write, or the bare show marker, as the block should emit it.
   typedef struct packed {
      logic               valid;
      logic [LIGHT_W-1:0] index;
      logic [HUE_W-1:0]   hue;
      logic [VALUE_W-1:0] value;
      logic               show;
   } pixel_write_type;

   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               start           = 1'b0;
   logic               req_operation   = OP_TICK;
   logic [LIGHT_W-1:0] req_light_index = '0;
   logic [HUE_W-1:0]   req_hue         = '0;
   logic               busy;
   logic               rsp_strobe;
   logic               rsp_pixel_valid;
   logic [LIGHT_W-1:0] rsp_pixel_index;
   logic [HUE_W-1:0]   rsp_pixel_hue;
   logic [VALUE_W-1:0] rsp_pixel_value;
   logic               rsp_show;

   // Copy of the animation state: the ring of future frames, the frame latched on
   // the strip, and the current-frame pointer.
   entry_type frame_mem [FRAMES][NUM_LIGHTS];
   entry_type shown_lights [NUM_LIGHTS];
   int        frame_ptr;

   command_type     pending_items[$];
   pixel_write_type expected_pixels[$];

   // The driver sees at the falling edge whether the rising edge before it took the
   // transaction on the request ports.
   logic        took = 1'b0;
   logic        launch;
   int          idle_left = -1;
   command_type next_cmd;
   int          total_items;
   int          accepted_count = 0;
   int          error_count = 0;
   int          stall_cycles = 0;
   bit          zero_gaps;
   int          hits;
   int          ticks;

   led_ripple_animation_scheduler_top #(
      .NUM_LIGHTS(NUM_LIGHTS),
      .FRAMES    (FRAMES)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_light_index(req_light_index),
      .req_hue        (req_hue),
      .rsp_strobe     (rsp_strobe),
      .rsp_pixel_valid(rsp_pixel_valid),
      .rsp_pixel_index(rsp_pixel_index),
      .rsp_pixel_hue  (rsp_pixel_hue),
      .rsp_pixel_value(rsp_pixel_value),
      .rsp_show       (rsp_show)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // A light with value zero is stored blank, hue included.
   function automatic entry_type lit_entry(input logic [HUE_W-1:0] hue, input int value);
      entry_type e;
      e = '0;
      if (value != 0) begin
         e.hue   = hue;
         e.value = VALUE_W'(value);
      end
      return e;
   endfunction

   // A hit paints 25 frames from the current one: the centre fades by two per frame,
   // and the ring around it widens by one light per frame up to ten, each step out
   // two dimmer, wrapping around the strip. Older content under the ripple is lost.
   function automatic void apply_ripple(input int centre, input logic [HUE_W-1:0] hue);
      int f;
      int reach;
      int peak;
      int side;
      int up;
      int dn;
      if (centre >= NUM_LIGHTS) return;
      for (int i = 0; i < RIPPLE_LEN; i++) begin
         peak  = (RIPPLE_LEN - i) * VALUE_STEP;
         f     = (frame_ptr + i) % FRAMES;
         reach = (i < RIPPLE_REACH) ? i : RIPPLE_REACH;
         frame_mem[f][centre] = lit_entry(hue, peak);
         for (int j = 1; j <= reach; j++) begin
            side = (peak > j * VALUE_STEP) ? peak - j * VALUE_STEP : 0;
            up   = (centre + j) % NUM_LIGHTS;
            dn   = (centre + NUM_LIGHTS - j) % NUM_LIGHTS;
            frame_mem[f][up] = lit_entry(hue, side);
            frame_mem[f][dn] = lit_entry(hue, side);
         end
      end
   endfunction

   // A tick writes every light that is lit now or was lit on the strip, in ascending
   // order, then clears the frame and moves on. The last write carries show; with
   // nothing to write, a bare all-zero show marker stands alone.
   function automatic void render_frame();
      pixel_write_type held;
      bit              have;
      held = '0;
      have = 1'b0;
      for (int l = 0; l < NUM_LIGHTS; l++) begin
         if (frame_mem[frame_ptr][l].value != 0 || shown_lights[l].value != 0) begin
            if (have) expected_pixels.push_back(held);
            shown_lights[l] = frame_mem[frame_ptr][l];
            held.valid = 1'b1;
            held.index = LIGHT_W'(l);
            held.hue   = shown_lights[l].hue;
            held.value = shown_lights[l].value;
            held.show  = 1'b0;
            have       = 1'b1;
         end
         frame_mem[frame_ptr][l] = '0;
      end
      held.show = 1'b1;
      expected_pixels.push_back(held);
      frame_ptr = (frame_ptr + 1) % FRAMES;
   endfunction

   function automatic void add_item(input logic op, input logic [LIGHT_W-1:0] light,
                                    input logic [HUE_W-1:0] hue, input int gap,
                                    input bit drain);
      command_type c;
      c.operation = op;
      c.light     = light;
      c.hue       = hue;
      c.gap       = gap;
      c.drain     = drain;
      pending_items.push_back(c);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Driver. Inputs only change at the falling edge. While start is up and the
   // transaction has not been taken, everything holds. Otherwise the head of the
   // queue first waits out its gap, and a draining item also waits for the
   // expected pixel writes to run dry; then it goes on the ports. When the next item
   // follows with no gap, start simply stays high across the boundary.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && !took)) begin
         launch = 1'b0;
         if (pending_items.size() != 0) begin
            if (idle_left < 0) idle_left = pending_items[0].gap;
            if (idle_left > 0) begin
               idle_left--;
            end else if (!pending_items[0].drain || expected_pixels.size() == 0) begin
               launch = 1'b1;
            end
         end
         if (launch) begin
            next_cmd = pending_items.pop_front();
            req_operation   <= next_cmd.operation;
            req_light_index <= next_cmd.light;
            req_hue         <= next_cmd.hue;
            start           <= 1'b1;
            idle_left = -1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor and predictor. At the rising edge a request transaction is taken when
   // start is high and busy low; its expected pixel writes join the back of the
   // queue. A strobe marks a result transaction, which is checked field by field
   // against the oldest expectation. A show from the previous tick may land on the
   // same edge as a new request; the queue keeps them in order either way.
   always @(posedge clock) begin
      pixel_write_type want;
      if (reset) begin
         took <= 1'b0;
      end else begin
         took <= start && !busy;
         if (start && !busy) begin
            accepted_count++;
            if (req_operation == OP_HIT) apply_ripple(int'(req_light_index), req_hue);
            else render_frame();
         end
         if (rsp_strobe) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch($sformatf("unexpected result for light %0d", rsp_pixel_index));
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_pixel_valid !== want.valid)
                  report_mismatch($sformatf("pixel_valid %0b, expected %0b",
                                            rsp_pixel_valid, want.valid));
               if (rsp_pixel_index !== want.index)
                  report_mismatch($sformatf("pixel_index %0d, expected %0d",
                                            rsp_pixel_index, want.index));
               if (rsp_pixel_hue !== want.hue)
                  report_mismatch($sformatf("pixel_hue %h, expected %h (light %0d)",
                                            rsp_pixel_hue, want.hue, want.index));
               if (rsp_pixel_value !== want.value)
                  report_mismatch($sformatf("pixel_value %0d, expected %0d (light %0d)",
                                            rsp_pixel_value, want.value, want.index));
               if (rsp_show !== want.show)
                  report_mismatch($sformatf("show %0b, expected %0b (light %0d)",
                                            rsp_show, want.show, want.index));
            end
         end
      end
   end

   // Watchdog: counts edges at which neither channel moves a transaction.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      for (int f = 0; f < FRAMES; f++)
         for (int l = 0; l < NUM_LIGHTS; l++)
            frame_mem[f][l] = '0;
      for (int l = 0; l < NUM_LIGHTS; l++)
         shown_lights[l] = '0;
      frame_ptr = 0;

      // Directed part. A tick on the cleared strip gives the bare show marker.
      add_item(OP_TICK, '0, '0, 0, 1'b0);
      // Ripples at both ends of the strip wrap around it, with extreme hues.
      add_item(OP_HIT, LIGHT_W'(0), 16'hFFFF, 0, 1'b0);
      add_item(OP_HIT, LIGHT_W'(NUM_LIGHTS - 1), 16'h0000, 0, 1'b0);
      for (int t = 0; t < 3; t++)
         add_item(OP_TICK, LIGHT_W'($urandom), HUE_W'($urandom), 0, 1'b0);
      // Two ripples side by side overwrite each other's rings.
      add_item(OP_HIT, LIGHT_W'(31), 16'hA5A5, int'($urandom_range(0, MAX_GAP)), 1'b0);
      add_item(OP_HIT, LIGHT_W'(32), 16'h5A5A, int'($urandom_range(0, MAX_GAP)), 1'b0);
      // The first of these ticks waits until everything owed has arrived. The run
      // of ticks that follows fades the ripples, lights dropping to blank
      // writes once their value reaches zero.
      add_item(OP_TICK, LIGHT_W'($urandom), HUE_W'($urandom), 0, 1'b1);
      for (int t = 0; t < 14; t++)
         add_item(OP_TICK, LIGHT_W'($urandom), HUE_W'($urandom),
                  int'($urandom_range(0, MAX_GAP)), 1'b0);

      // Random part, in episodes: a few hits, then a run of ticks that renders and
      // fades them. Some episodes carry no hits at all. About a third of the
      // episodes run back to back with no idle cycles.
      while (pending_items.size() < RANDOM_ITEMS) begin
         zero_gaps = ($urandom_range(0, 2) == 0);
         hits      = $urandom_range(0, 3);
         ticks     = $urandom_range(1, 30);
         for (int h = 0; h < hits; h++)
            add_item(OP_HIT,
                     ($urandom_range(0, 7) == 0) ?
                        (($urandom_range(0, 1) == 0) ? LIGHT_W'(0) : LIGHT_W'(NUM_LIGHTS - 1))
                        : LIGHT_W'($urandom_range(0, NUM_LIGHTS - 1)),
                     HUE_W'($urandom_range(0, 65535)),
                     zero_gaps ? 0 : int'($urandom_range(0, MAX_GAP)), 1'b0);
         for (int t = 0; t < ticks; t++)
            add_item(OP_TICK, LIGHT_W'($urandom), HUE_W'($urandom),
                     zero_gaps ? 0 : int'($urandom_range(0, MAX_GAP)),
                     (t == 0) && ($urandom_range(0, 19) == 0));
      end
      total_items = pending_items.size();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The block clears its frame memory first and holds busy meanwhile, so the
      // first transaction simply waits on the handshake.
      while (accepted_count < total_items || expected_pixels.size() != 0)
         @(posedge clock);
      // Let any late or stray result show up before the verdict.
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_pixels.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
